### hw/rtl/hacf_pkg.sv
`timescale 1ns / 1ps

package hacf_pkg;

    localparam logic [7:0] ASCII_HASH  = 8'h23;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_QMARK = 8'h3F;
    localparam logic [7:0] ASCII_V     = 8'h56;
    localparam logic [7:0] ASCII_R     = 8'h52;
    localparam logic [7:0] ASCII_S     = 8'h53;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_A_M10 = 8'h37;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [3:0] REPLY_LEN_QUERY = 4'd15;
    localparam logic [3:0] REPLY_LEN_SET   = 4'd12;

    localparam logic [4:0] BODY_LEN_QUERY = 5'd16;
    localparam logic [4:0] BODY_LEN_SET   = 5'd23;
    localparam logic [4:0] LAST_POS_QUERY = 5'd20;
    localparam logic [4:0] LAST_POS_SET   = 5'd27;

    localparam logic [7:0] INSTANCE_RESET = 8'd1;
    localparam logic       REG_INSTANCE   = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic at_last;
    } dp_status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            hex_char = ASCII_ZERO + {4'd0, nib};
        else
            hex_char = ASCII_A_M10 + {4'd0, nib};
    endfunction

    function automatic logic [3:0] nib16(input logic [15:0] v, input logic [1:0] k);
        nib16 = v[{k, 2'b00} +: 4];
    endfunction

    function automatic logic [3:0] nib32(input logic [31:0] v, input logic [2:0] k);
        nib32 = v[{k, 2'b00} +: 4];
    endfunction

    // msb first, bitwise over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        crc_byte = c;
    endfunction

    function automatic logic [7:0] frame_char(
        input logic        is_set,
        input logic [4:0]  p,
        input logic [7:0]  addr,
        input logic [15:0] seq,
        input logic [15:0] pid,
        input logic [7:0]  inst,
        input logic [31:0] val,
        input logic [15:0] crc
    );
        logic [7:0] b;
        b = ASCII_HASH;
        if (is_set)
        begin
            case (p) inside
                5'd0:            b = ASCII_HASH;
                5'd1:            b = hex_char(addr[7:4]);
                5'd2:            b = hex_char(addr[3:0]);
                [5'd3:5'd6]:     b = hex_char(nib16(seq, 2'(5'd6 - p)));
                5'd7:            b = ASCII_V;
                5'd8:            b = ASCII_S;
                [5'd9:5'd12]:    b = hex_char(nib16(pid, 2'(5'd12 - p)));
                5'd13:           b = hex_char(inst[7:4]);
                5'd14:           b = hex_char(inst[3:0]);
                [5'd15:5'd22]:   b = hex_char(nib32(val, 3'(5'd22 - p)));
                [5'd23:5'd26]:   b = hex_char(nib16(crc, 2'(5'd26 - p)));
                default:         b = ASCII_CR;
            endcase
        end
        else
        begin
            case (p) inside
                5'd0:            b = ASCII_HASH;
                5'd1:            b = hex_char(addr[7:4]);
                5'd2:            b = hex_char(addr[3:0]);
                [5'd3:5'd6]:     b = hex_char(nib16(seq, 2'(5'd6 - p)));
                5'd7:            b = ASCII_QMARK;
                5'd8:            b = ASCII_V;
                5'd9:            b = ASCII_R;
                [5'd10:5'd13]:   b = hex_char(nib16(pid, 2'(5'd13 - p)));
                5'd14:           b = hex_char(inst[7:4]);
                5'd15:           b = hex_char(inst[3:0]);
                [5'd16:5'd19]:   b = hex_char(nib16(crc, 2'(5'd19 - p)));
                default:         b = ASCII_CR;
            endcase
        end
        frame_char = b;
    endfunction

endpackage

### hw/rtl/hacf_ctrl.sv
`timescale 1ns / 1ps

module hacf_ctrl
    import hacf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.slot_free)
                begin
                    cmd.step = 1'b1;
                    if (status.at_last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

### hw/rtl/hacf_dp.sv
`timescale 1ns / 1ps

module hacf_dp
    import hacf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        cmd_in,
    input  logic [7:0]  addr_in,
    input  logic [15:0] pid_in,
    input  logic [31:0] val_in,
    input  logic [7:0]  instance_num,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    output logic [3:0]  expected_reply_length,
    output logic [15:0] sequence_used
);

    logic        is_set_reg;
    logic [7:0]  addr_reg;
    logic [15:0] pid_reg;
    logic [31:0] val_reg;
    logic [15:0] seq_reg;
    logic [15:0] crc_reg;
    logic [4:0]  pos_reg;

    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [3:0]  reply_reg;
    logic [15:0] seq_out_reg;

    logic [7:0]  char_next;
    logic [4:0]  body_len;
    logic [4:0]  last_pos;

    assign body_len  = is_set_reg ? BODY_LEN_SET : BODY_LEN_QUERY;
    assign last_pos  = is_set_reg ? LAST_POS_SET : LAST_POS_QUERY;
    assign char_next = frame_char(is_set_reg, pos_reg, addr_reg, seq_reg, pid_reg,
                                  instance_num, val_reg, crc_reg);

    assign status.slot_free = !out_valid_reg || out_ready;
    assign status.at_last   = (pos_reg == last_pos);

    // request fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_set_reg <= cmd_in;
            addr_reg   <= addr_in;
            pid_reg    <= pid_in;
            val_reg    <= val_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= '0;
            crc_reg <= '0;
            pos_reg <= '0;
        end
        else if (cmd.load)
        begin
            seq_reg <= seq_reg + 16'd1;
            crc_reg <= '0;
            pos_reg <= '0;
        end
        else if (cmd.step)
        begin
            // crc runs over the body bytes as they are produced
            if (pos_reg < body_len)
                crc_reg <= crc_byte(crc_reg, char_next);
            pos_reg <= pos_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output slot keeps its own copy so a new request can load underneath
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            byte_reg    <= char_next;
            last_reg    <= status.at_last;
            reply_reg   <= is_set_reg ? REPLY_LEN_SET : REPLY_LEN_QUERY;
            seq_out_reg <= seq_reg;
        end
    end

    assign out_valid             = out_valid_reg;
    assign frame_byte            = byte_reg;
    assign last_byte             = last_reg;
    assign expected_reply_length = reply_reg;
    assign sequence_used         = seq_out_reg;

endmodule

### hw/rtl/hex_ascii_command_framer_crc16_top.sv
`timescale 1ns / 1ps

// ascii hex request framer with crc-16/xmodem
// input channel (in_valid/in_ready): one request per transfer, cmd selects
// read query (0) or set command (1), with address, parameter id and value.
// output channel (out_valid/out_ready): one frame byte per transfer, with
// last_byte on the closing carriage return; expected_reply_length and
// sequence_used accompany every byte of the frame.
// a request is taken only while no frame is being built; after the request
// transfer the sequencer enters its run state and registers the first byte
// into the output slot, then one byte per cycle unless the output stalls.
// a query frame has 21 bytes, a set frame 28.
// the crc is folded in one byte per cycle as the body bytes pass, unless stalled.
// a stalled receiver holds the current byte in the output register and the
// sequencer waits; the next request may be taken while the last byte waits.
// reset clears the sequence counter (first frame uses 1), empties the output
// and sets instance_number to 1. instance_number is written through the apb
// port at byte address 0.
module hex_ascii_command_framer_crc16_top
    import hacf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  device_address,
    input  logic [15:0] parameter_id,
    input  logic [31:0] set_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    output logic [3:0]  expected_reply_length,
    output logic [15:0] sequence_used
);

    logic [7:0] instance_reg;
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            instance_reg <= INSTANCE_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_INSTANCE))
            instance_reg <= pwdata[7:0];
    end

    assign prdata = (paddr[2] == REG_INSTANCE) ? {24'd0, instance_reg} : 32'd0;

    hacf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (dp_cmd),
        .status   (dp_status)
    );

    hacf_dp u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (dp_cmd),
        .status                (dp_status),
        .cmd_in                (cmd),
        .addr_in               (device_address),
        .pid_in                (parameter_id),
        .val_in                (set_value),
        .instance_num          (instance_reg),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .frame_byte            (frame_byte),
        .last_byte             (last_byte),
        .expected_reply_length (expected_reply_length),
        .sequence_used         (sequence_used)
    );

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while a frame is still being built");

    a_last_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_byte |-> frame_byte == ASCII_CR)
        else $error("last byte of frame is not a carriage return");

    a_reply_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (expected_reply_length == REPLY_LEN_QUERY ||
                       expected_reply_length == REPLY_LEN_SET))
        else $error("reply length outside the two frame kinds");

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import hacf_pkg::*;

    localparam logic       CMD_QUERY      = 1'b0;
    localparam logic       CMD_SET        = 1'b1;
    localparam logic [2:0] INSTANCE_ADDR  = 3'(4 * REG_INSTANCE);
    localparam int         LONG_HOLD      = 400;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         SETTLE_CYCLES  = 30;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  addr;
        logic [15:0] pid;
        logic [31:0] value;
        logic        wait_idle;
    } request_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic [3:0]  reply_len;
        logic [15:0] seq;
    } frame_byte_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [7:0]  device_address;
    logic [15:0] parameter_id;
    logic [31:0] set_value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [3:0]  expected_reply_length;
    logic [15:0] sequence_used;

    request_t    req_q[$];
    frame_byte_t frame_q[$];
    logic [7:0]  body[$];

    logic [15:0] seq_model;
    logic [7:0]  inst_model;
    bit          in_taken;
    int          fail_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_requests;
    int          hold_seen;
    int          hold_left;
    int          quiet_cycles;

    hex_ascii_command_framer_crc16_top u_top (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .cmd                   (cmd),
        .device_address        (device_address),
        .parameter_id          (parameter_id),
        .set_value             (set_value),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .frame_byte            (frame_byte),
        .last_byte             (last_byte),
        .expected_reply_length (expected_reply_length),
        .sequence_used         (sequence_used)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        return (n < 4'd10 ? ASCII_ZERO : ASCII_A_M10) + 8'(n);
    endfunction

    task automatic add_hex(input logic [31:0] v, input int ndig);
        for (int i = ndig - 1; i >= 0; i--)
            body.push_back(hex_ascii(4'(v >> (4 * i))));
    endtask

    // builds the whole frame for one request and queues its bytes
    task automatic predict_frame(input logic is_set, input logic [7:0] addr,
                                 input logic [15:0] pid, input logic [31:0] value);
        logic [15:0] crc;
        logic [3:0]  rlen;
        logic        fbit;
        frame_byte_t fb;
        seq_model = seq_model + 16'd1;
        rlen = is_set ? REPLY_LEN_SET : REPLY_LEN_QUERY;
        body.delete();
        body.push_back(ASCII_HASH);
        add_hex(32'(addr), 2);
        add_hex(32'(seq_model), 4);
        if (is_set)
        begin
            body.push_back(ASCII_V);
            body.push_back(ASCII_S);
        end
        else
        begin
            body.push_back(ASCII_QMARK);
            body.push_back(ASCII_V);
            body.push_back(ASCII_R);
        end
        add_hex(32'(pid), 4);
        add_hex(32'(inst_model), 2);
        if (is_set)
            add_hex(value, 8);
        // bit-serial crc, msb first
        crc = '0;
        foreach (body[i])
        begin
            for (int b = 7; b >= 0; b--)
            begin
                fbit = crc[15] ^ body[i][b];
                crc = {crc[14:0], 1'b0} ^ (fbit ? CRC_POLY : 16'h0000);
            end
        end
        add_hex(32'(crc), 4);
        body.push_back(ASCII_CR);
        foreach (body[i])
        begin
            fb.ch        = body[i];
            fb.last      = (i == body.size() - 1);
            fb.reply_len = rlen;
            fb.seq       = seq_model;
            frame_q.push_back(fb);
        end
    endtask

    task automatic log_mismatch(input string why, input frame_byte_t want,
                                input frame_byte_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: expected byte %h last %b len %0d seq %h, got byte %h last %b len %0d seq %h",
                     why, want.ch, want.last, want.reply_len, want.seq,
                     got.ch, got.last, got.reply_len, got.seq);
    endtask

    function automatic request_t random_request(input int set_pct);
        request_t r;
        r.cmd   = ($urandom_range(0, 99) < set_pct) ? CMD_SET : CMD_QUERY;
        r.addr  = 8'($urandom());
        r.pid   = 16'($urandom());
        r.value = $urandom();
        if ($urandom_range(0, 9) == 0)
            r.addr = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
        if ($urandom_range(0, 9) == 0)
            r.pid = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
        if ($urandom_range(0, 9) == 0)
            r.value = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        r.wait_idle = ($urandom_range(0, 39) == 0);
        return r;
    endfunction

    // request side: prediction at the transfer
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
            predict_frame(cmd, device_address, parameter_id, set_value);
    end

    // sender
    always @(negedge clk)
    begin
        request_t nxt;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (req_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct
                && !(req_q[0].wait_idle && frame_q.size() != 0))
            begin
                nxt = req_q.pop_front();
                in_valid       <= 1'b1;
                cmd            <= nxt.cmd;
                device_address <= nxt.addr;
                parameter_id   <= nxt.pid;
                set_value      <= nxt.value;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        frame_byte_t got;
        frame_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{frame_byte, last_byte, expected_reply_length, sequence_used};
            if (frame_q.size() == 0)
                log_mismatch("frame byte with none expected", '0, got);
            else
            begin
                want = frame_q.pop_front();
                if (got !== want)
                    log_mismatch("frame byte mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= INSTANCE_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // junk in the upper data bits must be dropped by the register
    task automatic set_instance(input logic [7:0] v, input logic do_write);
        logic [31:0] rd;
        if (do_write)
        begin
            apb_access(1'b1, {24'($urandom()), v}, rd);
            inst_model = v;
        end
        apb_access(1'b0, 32'h0, rd);
        if (rd !== {24'h0, v})
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("instance readback: expected %h, got %h", {24'h0, v}, rd);
        end
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || in_valid || frame_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int set_pct, input int tx_pct,
                             input int rx_pct, input bit with_hold);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < n; i++)
            req_q.push_back(random_request(set_pct));
        if (with_hold)
        begin
            repeat (40) @(posedge clk);
            hold_requests++;
        end
        wait_drained();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        cmd            = CMD_QUERY;
        device_address = '0;
        parameter_id   = '0;
        set_value      = '0;
        out_ready      = 1'b0;
        seq_model      = '0;
        inst_model     = INSTANCE_RESET;
        fail_count     = 0;
        tx_idle_pct    = 29;
        rx_idle_pct    = 68;
        hold_requests  = 0;
        hold_seen      = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_instance(INSTANCE_RESET, 1'b0);

        // extremes, every hex digit, both commands, query value ignored
        req_q.push_back(request_t'{CMD_QUERY, 8'h00, 16'h0000, 32'h0000_0000, 1'b0});
        req_q.push_back(request_t'{CMD_SET,   8'h00, 16'h0000, 32'h0000_0000, 1'b0});
        req_q.push_back(request_t'{CMD_QUERY, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1});
        req_q.push_back(request_t'{CMD_SET,   8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0});
        req_q.push_back(request_t'{CMD_SET,   8'h5A, 16'hA5C3, 32'h0123_4567, 1'b0});
        req_q.push_back(request_t'{CMD_SET,   8'hB7, 16'h1E2D, 32'h89AB_CDEF, 1'b0});
        req_q.push_back(request_t'{CMD_QUERY, 8'h09, 16'h1234, 32'hDEAD_BEEF, 1'b0});
        req_q.push_back(request_t'{CMD_QUERY, 8'h09, 16'h1234, 32'h0000_0001, 1'b0});
        req_q.push_back(request_t'{CMD_QUERY, 8'hC6, 16'h89AB, 32'h0000_0000, 1'b1});
        req_q.push_back(request_t'{CMD_SET,   8'h80, 16'h8000, 32'h8000_0000, 1'b0});
        req_q.push_back(request_t'{CMD_SET,   8'h01, 16'h0001, 32'h0000_0001, 1'b0});
        req_q.push_back(request_t'{CMD_QUERY, 8'h7F, 16'h7FFF, 32'h7FFF_FFFF, 1'b0});
        req_q.push_back(request_t'{CMD_QUERY, 8'hED, 16'hCBA9, 32'h5555_AAAA, 1'b0});
        wait_drained();

        // all-ones instance field
        set_instance(8'hFF, 1'b1);
        run_phase(10, 50, 29, 68, 1'b0);

        set_instance(8'h00, 1'b1);
        run_phase(120, 50, 29, 68, 1'b0);

        set_instance(8'($urandom()), 1'b1);
        run_phase(120, 50, 68, 29, 1'b0);

        set_instance(8'($urandom()), 1'b1);
        run_phase(120, 50, 0, 0, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
